### hdl/sscd_pkg.sv
// package for the sensor scan change detector
// holds codes, controller state type, the command and status structs and the msb_index helper
// no dependencies
package sscd_pkg;

	localparam int WORD_BITS = 16;
	localparam int BYTE_BITS = 8;
	localparam int ID_W      = 5;
	localparam int MIDX_W    = 3;
	localparam int TIME_W    = 32;

	localparam logic ACT_POLL    = 1'b0;
	localparam logic ACT_RECEIPT = 1'b1;

	localparam logic KIND_CHANGE = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} sscd_state_t;

	typedef struct packed {
		logic accept;
		logic pop;
	} sscd_cmd_t;

	typedef struct packed {
		logic pair_end;
		logic pending;
		logic wrap;
		logic last;
	} sscd_status_t;

	// index of the highest set bit, zero when none
	function automatic logic [3:0] msb_index(input logic [WORD_BITS-1:0] v);
		logic [3:0] r;
		r = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (v[i]) begin
				r = 4'(i);
			end
		end
		return r;
	endfunction

endpackage

### hdl/sscd_channels.sv
// handshake channels of the sensor scan change detector
// sscd_poll_if carries input beats, sscd_event_if carries result beats
// depends on sscd_pkg
interface sscd_poll_if import sscd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 action;
	logic [BYTE_BITS-1:0] byte_value;
	logic [TIME_W-1:0]    query_time;

	modport source (output valid, action, byte_value, query_time, input ready);
	modport sink   (input valid, action, byte_value, query_time, output ready);
endinterface

interface sscd_event_if import sscd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              event_kind;
	logic [MIDX_W-1:0] module_index;
	logic [ID_W-1:0]   sensor_id;
	logic              sensor_on;
	logic [TIME_W-1:0] event_time;
	logic              last_of_run;

	modport source (output valid, event_kind, module_index, sensor_id, sensor_on,
		event_time, last_of_run, input ready);
	modport sink   (input valid, event_kind, module_index, sensor_id, sensor_on,
		event_time, last_of_run, output ready);
endinterface

### hdl/sscd_ctrl.sv
// controller of the sensor scan change detector
// accepts beats when idle and walks the pending changes one beat at a time
// depends on sscd_pkg
module sscd_ctrl import sscd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  sscd_status_t status,
	output sscd_cmd_t    cmd
);

	sscd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		cmd.accept = 1'b0;
		cmd.pop    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.pair_end) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (!status.pending && !status.wrap) begin
					state_d = ST_IDLE;
				end else begin
					out_valid = 1'b1;
					if (out_ready) begin
						cmd.pop = 1'b1;
						if (status.last) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hdl/sscd_dpath.sv
// datapath of the sensor scan change detector
// module word store, byte pairing, query timestamps and change bit walk
// depends on sscd_pkg
module sscd_dpath import sscd_pkg::*; #(
	parameter int NUM_MODULES = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sscd_cmd_t            cmd,
	output sscd_status_t         status,
	input  logic                 action,
	input  logic [BYTE_BITS-1:0] byte_value,
	input  logic [TIME_W-1:0]    query_time,
	output logic                 event_kind,
	output logic [MIDX_W-1:0]    module_index,
	output logic [ID_W-1:0]      sensor_id,
	output logic                 sensor_on,
	output logic [TIME_W-1:0]    event_time,
	output logic                 last_of_run
);

	localparam int MOD_W = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
	localparam logic [MOD_W-1:0] MOD_LAST = MOD_W'(NUM_MODULES - 1);

	logic [WORD_BITS-1:0] words_q [NUM_MODULES];
	logic                 phase_q;
	logic [BYTE_BITS-1:0] high_q;
	logic [MOD_W-1:0]     mod_q;
	logic [TIME_W-1:0]    prev_time_q;
	logic [TIME_W-1:0]    stamp_q;
	logic [WORD_BITS-1:0] diff_q;
	logic [WORD_BITS-1:0] word_q;
	logic [MOD_W-1:0]     idx_q;
	logic                 wrap_q;

	logic [WORD_BITS-1:0] new_word;
	logic [TIME_W:0]      mid_sum;
	logic [3:0]           top_bit;
	logic                 one_left;
	logic                 pair_done;

	assign new_word  = {high_q, byte_value};
	assign mid_sum   = {1'b0, prev_time_q} + {1'b0, query_time};
	assign top_bit   = msb_index(diff_q);
	assign one_left  = (diff_q != '0) && ((diff_q & (diff_q - 1'b1)) == '0);
	assign pair_done = cmd.accept && (action == ACT_POLL) && phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < NUM_MODULES; m++) begin
				words_q[m] <= '0;
			end
			phase_q     <= 1'b0;
			high_q      <= '0;
			mod_q       <= '0;
			prev_time_q <= '0;
			stamp_q     <= '0;
			diff_q      <= '0;
			wrap_q      <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (action == ACT_RECEIPT) begin
					stamp_q     <= mid_sum[TIME_W:1];
					prev_time_q <= query_time;
				end else if (!phase_q) begin
					phase_q <= 1'b1;
					high_q  <= byte_value;
				end else begin
					phase_q        <= 1'b0;
					words_q[mod_q] <= new_word;
					diff_q         <= new_word ^ words_q[mod_q];
					wrap_q         <= (mod_q == MOD_LAST);
					mod_q          <= (mod_q == MOD_LAST) ? '0 : mod_q + 1'b1;
				end
			end else if (cmd.pop) begin
				if (diff_q != '0) begin
					diff_q[top_bit] <= 1'b0;
				end else begin
					wrap_q <= 1'b0;
				end
			end
		end
	end

	// payload of the pair being walked
	always_ff @(posedge clk) begin
		if (pair_done) begin
			word_q <= new_word;
			idx_q  <= mod_q;
		end
	end

	always_comb begin
		status.pair_end = (action == ACT_POLL) && phase_q;
		status.pending  = (diff_q != '0);
		status.wrap     = wrap_q;
		status.last     = (diff_q == '0) || (one_left && !wrap_q);
	end

	always_comb begin
		if (diff_q != '0) begin
			event_kind   = KIND_CHANGE;
			module_index = MIDX_W'(idx_q);
			sensor_id    = ID_W'(WORD_BITS) - ID_W'(top_bit);
			sensor_on    = word_q[top_bit];
			event_time   = stamp_q;
		end else begin
			event_kind   = KIND_QUERY;
			module_index = '0;
			sensor_id    = '0;
			sensor_on    = 1'b0;
			event_time   = '0;
		end
		last_of_run = status.last;
	end

endmodule

### hdl/sensor_scan_change_detector.sv
// top level of the sensor scan change detector
// joins controller and datapath, depends on sscd_pkg, sscd_channels, sscd_ctrl, sscd_dpath
//
//   channel  dir  beat contents
//   poll     in   action, byte_value, query_time
//   evt      out  event_kind, module_index, sensor_id, sensor_on, event_time, last_of_run
//
// a high byte or a query receipt is taken in the idle state and gives no result
// a low byte is followed by one result beat per changed sensor bit, plus a query
// beat when the module counter wraps (up to 17); with no result it still passes ST_EMIT
// poll is not ready while results of a pair are pending; evt stalls hold the walk
// reset clears the module words, byte phase, module counter and timestamps
module sensor_scan_change_detector import sscd_pkg::*; #(
	parameter int NUM_MODULES = 5
) (
	input logic         clk,
	input logic         arst_n,
	sscd_poll_if.sink   poll,
	sscd_event_if.source evt
);

	sscd_cmd_t    cmd;
	sscd_status_t status;

	sscd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (poll.valid),
		.in_ready  (poll.ready),
		.out_valid (evt.valid),
		.out_ready (evt.ready),
		.status    (status),
		.cmd       (cmd)
	);

	sscd_dpath #(
		.NUM_MODULES (NUM_MODULES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.action       (poll.action),
		.byte_value   (poll.byte_value),
		.query_time   (poll.query_time),
		.event_kind   (evt.event_kind),
		.module_index (evt.module_index),
		.sensor_id    (evt.sensor_id),
		.sensor_on    (evt.sensor_on),
		.event_time   (evt.event_time),
		.last_of_run  (evt.last_of_run)
	);

endmodule
